>>> rtl/pcpg_pkg.sv
// ----------------------------------------------------------------------------
// pcpg_pkg
// Shared types, curve tables and helpers of the curve point generator.
// ----------------------------------------------------------------------------
`default_nettype none

package pcpg_pkg;

  localparam int unsigned SINE_TABLE_BITS_DEF = 10;
  localparam int unsigned MAX_STEPS_DEF       = 512;

  localparam int unsigned IDX_W      = 10;
  localparam int unsigned PHASE_W    = 32;
  localparam int unsigned ROM_W      = 17;
  localparam int unsigned VAL_W      = 18;
  localparam int unsigned PT_W       = 24;
  localparam int unsigned T_W        = 20;
  localparam int unsigned PIX_W      = 12;
  localparam int unsigned CENTER_W   = 10;
  localparam int unsigned SCALE_W    = 8;
  localparam int unsigned SEL_W      = 4;
  localparam int unsigned NUM_CURVES = 11;
  localparam int unsigned MAX_KDEN   = 14;
  localparam int unsigned ADDR_W     = 4;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned LATENCY    = 7;

  localparam longint unsigned HALF_PI_Q30   = 64'd1686629713;
  localparam longint unsigned PI_Q30        = 64'd3373259426;
  localparam int unsigned     ELLIPSE_B_Q16 = 72090;
  localparam int unsigned     ONE_Q16       = 65536;

  // Taylor series divisors (2k)(2k+1), entry 0 unused
  localparam longint unsigned TAYLOR_DIV [10] =
    '{1, 6, 20, 42, 72, 110, 156, 210, 272, 342};

  localparam logic [1:0] REG_CURVE    = 2'd0;
  localparam logic [1:0] REG_CENTER_X = 2'd1;
  localparam logic [1:0] REG_CENTER_Y = 2'd2;

  localparam logic [SEL_W-1:0]    CURVE_RESET    = 4'd0;
  localparam logic [CENTER_W-1:0] CENTER_X_RESET = 10'd199;
  localparam logic [CENTER_W-1:0] CENTER_Y_RESET = 10'd199;

  typedef enum logic [SEL_W-1:0] {
    CURVE_ASTROID  = 4'd0,
    CURVE_CYCLOID  = 4'd1,
    CURVE_HYPO     = 4'd2,
    CURVE_HUYGENS  = 4'd3,
    CURVE_LINE     = 4'd4,
    CURVE_CIRCLE   = 4'd5,
    CURVE_ELLIPSE  = 4'd6,
    CURVE_FANCY    = 4'd7,
    CURVE_STARFISH = 4'd8,
    CURVE_CLOUD    = 4'd9,
    CURVE_ICLOUD   = 4'd10
  } curve_t;

  localparam int unsigned CURVE_SCALE [NUM_CURVES] =
    '{90, 10, 40, 10, 100, 165, 75, 10, 25, 10, 10};
  localparam int unsigned CURVE_SPAN  [NUM_CURVES] =
    '{2, 4, 2, 4, 2, 2, 2, 12, 6, 28, 28};
  localparam int unsigned CURVE_STEPS [NUM_CURVES] =
    '{256, 128, 256, 256, 128, 128, 256, 512, 256, 128, 128};
  localparam int unsigned KA_NUM [NUM_CURVES] = '{1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1};
  localparam int unsigned KA_DEN [NUM_CURVES] = '{1, 1, 1, 1, 1, 1, 1, 1, 1, 14, 14};
  localparam int unsigned KB_NUM [NUM_CURVES] = '{1, 1, 2, 3, 1, 1, 1, 11, 2, 15, 15};
  localparam int unsigned KB_DEN [NUM_CURVES] = '{1, 1, 1, 1, 1, 1, 1, 6, 3, 14, 14};

  typedef struct packed {
    logic                 valid;
    logic                 at_end;
    logic [IDX_W-1:0]     i;
    logic [T_W-1:0]       t;
    logic [PHASE_W-1:0]   pa;
    logic [PHASE_W-1:0]   pb;
  } phase_t;

  typedef struct packed {
    logic                   valid;
    logic                   at_end;
    logic signed [PT_W-1:0] x;
    logic signed [PT_W-1:0] y;
  } point_t;

  function automatic logic [ROM_W-1:0] sine_entry(input int unsigned j,
                                                  input int unsigned bits);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint signed   sum;
    longint unsigned rnd;
    x    = (longint'(j) * HALF_PI_Q30) >> bits;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (int k = 1; k <= 9; k++) begin
      term = ((term * x2) >> 30) / TAYLOR_DIV[k];
      if ((k % 2) == 1) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    rnd = (longint'(sum) + 64'd8192) >> 14;
    return ROM_W'(rnd);
  endfunction

  function automatic logic signed [PT_W-1:0] half_tz(input logic signed [PT_W-1:0] v);
    return (v + $signed({{(PT_W-1){1'b0}}, v[PT_W-1]})) >>> 1;
  endfunction

endpackage

`default_nettype wire

>>> rtl/parametric_curve_point_generator_core.sv
// ----------------------------------------------------------------------------
// parametric_curve_point_generator_core
// Step index in, one saturated screen pixel of the selected curve out.
// ----------------------------------------------------------------------------
// The core takes one step index in every clock cycle: busy stays low, and
// each transfer gives one result on pixel_x, pixel_y and end_of_curve, shown
// for one cycle under done. The seven register stages are the phase divider
// (three), the sine table read, the curve equations, the astroid cube
// multiply and the scale-and-saturate stage; four table ROMs of
// 2^SINE_TABLE_BITS+1 entries serve the lookups. The receiver cannot stall
// results, and no clearing pass follows reset.
// Change curve_select, center_x or center_y only while no item is in flight.
`default_nettype none

module parametric_curve_point_generator_core #(
  parameter int unsigned SINE_TABLE_BITS = pcpg_pkg::SINE_TABLE_BITS_DEF,
  parameter int unsigned MAX_STEPS       = pcpg_pkg::MAX_STEPS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [pcpg_pkg::IDX_W-1:0]        step_index,
  output logic                              done,
  output logic signed [pcpg_pkg::PIX_W-1:0] pixel_x,
  output logic signed [pcpg_pkg::PIX_W-1:0] pixel_y,
  output logic                              end_of_curve,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [pcpg_pkg::ADDR_W-1:0]       paddr,
  input  logic [pcpg_pkg::DATA_W-1:0]       pwdata,
  output logic [pcpg_pkg::DATA_W-1:0]       prdata,
  output logic                              pready
);
  import pcpg_pkg::*;

  localparam int unsigned SUM_W = PT_W + SCALE_W + 4;

  logic [SEL_W-1:0]    curve_select;
  logic [CENTER_W-1:0] center_x;
  logic [CENTER_W-1:0] center_y;

  assign pready = 1'b1;
  assign busy   = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      curve_select <= CURVE_RESET;
      center_x     <= CENTER_X_RESET;
      center_y     <= CENTER_Y_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr[ADDR_W-1:2])
        REG_CURVE:    curve_select <= pwdata[SEL_W-1:0];
        REG_CENTER_X: center_x     <= pwdata[CENTER_W-1:0];
        REG_CENTER_Y: center_y     <= pwdata[CENTER_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[ADDR_W-1:2])
      REG_CURVE:    prdata = DATA_W'(curve_select);
      REG_CENTER_X: prdata = DATA_W'(center_x);
      REG_CENTER_Y: prdata = DATA_W'(center_y);
      default:      prdata = '0;
    endcase
  end

  phase_t phase;
  point_t point;

  pcpg_phase #(.MAX_STEPS(MAX_STEPS)) u_phase (
    .clk(clk), .rst(rst), .in_valid(start && !busy), .step_index(step_index),
    .curve_select(curve_select), .phase_out(phase)
  );

  pcpg_point #(.TABLE_BITS(SINE_TABLE_BITS)) u_point (
    .clk(clk), .rst(rst), .curve_select(curve_select), .phase_in(phase),
    .point_out(point)
  );

  logic [SCALE_W-1:0] scale;

  always_comb begin
    scale = '0;
    if (curve_select < SEL_W'(NUM_CURVES)) scale = SCALE_W'(CURVE_SCALE[curve_select]);
  end

  function automatic logic signed [PIX_W-1:0] to_pixel(input logic signed [PT_W-1:0] v,
                                                       input logic [SCALE_W-1:0] s,
                                                       input logic [CENTER_W-1:0] c);
    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] q;
    sum = SUM_W'(v * $signed({1'b0, s})) + $signed({{(SUM_W-CENTER_W-16){1'b0}}, c, 16'b0});
    q   = (sum + $signed({{(SUM_W-16){1'b0}}, {16{sum[SUM_W-1]}}})) >>> 16;
    if (q > SUM_W'(2047)) return PIX_W'(2047);
    if (q < -SUM_W'(2048)) return PIX_W'(-2048);
    return q[PIX_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= point.valid;
    end_of_curve <= point.at_end;
    pixel_x      <= to_pixel(point.x, scale, center_x);
    pixel_y      <= to_pixel(point.y, scale, center_y);
  end

endmodule

`default_nettype wire

>>> rtl/pcpg_sine_rom.sv
// ----------------------------------------------------------------------------
// pcpg_sine_rom
// Quarter-wave sine table in Q1.16 with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module pcpg_sine_rom #(
  parameter int unsigned TABLE_BITS = pcpg_pkg::SINE_TABLE_BITS_DEF
) (
  input  logic                       clk,
  input  logic [TABLE_BITS:0]        addr,
  output logic [pcpg_pkg::ROM_W-1:0] data
);
  import pcpg_pkg::*;

  localparam int unsigned DEPTH = (1 << TABLE_BITS) + 1;

  logic [ROM_W-1:0] rom [DEPTH];

  for (genvar g = 0; g < DEPTH; g++) begin : g_rom
    localparam logic [ROM_W-1:0] ENTRY = sine_entry(g, TABLE_BITS);
    assign rom[g] = ENTRY;
  end

  always_ff @(posedge clk) begin
    data <= rom[addr];
  end

endmodule

`default_nettype wire

>>> rtl/pcpg_phase.sv
// ----------------------------------------------------------------------------
// pcpg_phase
// Clamps the index and forms the two rounded 32-bit phases of each point.
// ----------------------------------------------------------------------------
`default_nettype none

module pcpg_phase #(
  parameter int unsigned MAX_STEPS = pcpg_pkg::MAX_STEPS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic [pcpg_pkg::IDX_W-1:0] step_index,
  input  logic [pcpg_pkg::SEL_W-1:0] curve_select,
  output pcpg_pkg::phase_t           phase_out
);
  import pcpg_pkg::*;

  localparam int unsigned DEN_W = $clog2(2 * MAX_STEPS * MAX_KDEN + 1);
  localparam int unsigned X_W   = DEN_W + IDX_W;
  localparam int unsigned M_W   = X_W - 7;
  localparam int unsigned R_W   = IDX_W + 1;
  localparam longint unsigned CYC_MUL = 4 * PI_Q30;
  localparam longint unsigned CYC_RND = 64'd1 << 20;

  logic [PHASE_W-1:0] qa_tab   [2][NUM_CURVES];
  logic [DEN_W-1:0]   ra_tab   [2][NUM_CURVES];
  logic [DEN_W-1:0]   half_tab [2][NUM_CURVES];
  logic [DEN_W-1:0]   den_tab  [2][NUM_CURVES];
  logic [M_W-1:0]     mq_tab   [2][NUM_CURVES];
  logic [IDX_W-1:0]   n_tab    [NUM_CURVES];

  for (genvar c = 0; c < NUM_CURVES; c++) begin : g_curve
    localparam longint unsigned NC =
      (CURVE_STEPS[c] > MAX_STEPS) ? MAX_STEPS : CURVE_STEPS[c];
    assign n_tab[c] = IDX_W'(NC);
    for (genvar ab = 0; ab < 2; ab++) begin : g_ph
      localparam longint unsigned KN  = (ab == 0) ? KA_NUM[c] : KB_NUM[c];
      localparam longint unsigned KD  = (ab == 0) ? KA_DEN[c] : KB_DEN[c];
      localparam longint unsigned DEN = 2 * NC * KD;
      localparam longint unsigned NUM = (longint'(CURVE_SPAN[c]) * KN) << 32;
      localparam longint unsigned QA  = NUM / DEN;
      localparam longint unsigned RA  = NUM % DEN;
      localparam longint unsigned MQ  = (64'd1 << X_W) / DEN;
      localparam longint unsigned HALF_DEN = DEN / 2;
      assign qa_tab[ab][c]   = PHASE_W'(QA);
      assign ra_tab[ab][c]   = DEN_W'(RA);
      assign half_tab[ab][c] = DEN_W'(HALF_DEN);
      assign den_tab[ab][c]  = DEN_W'(DEN);
      assign mq_tab[ab][c]   = M_W'(MQ);
    end
  end

  logic [PHASE_W-1:0] qa   [2];
  logic [DEN_W-1:0]   ra   [2];
  logic [DEN_W-1:0]   half [2];
  logic [DEN_W-1:0]   den  [2];
  logic [M_W-1:0]     mq   [2];
  logic [IDX_W-1:0]   n;

  always_comb begin
    n = '0;
    for (int ab = 0; ab < 2; ab++) begin
      qa[ab]   = '0;
      ra[ab]   = '0;
      half[ab] = '0;
      den[ab]  = '1;
      mq[ab]   = '0;
    end
    if (curve_select < SEL_W'(NUM_CURVES)) begin
      n = n_tab[curve_select];
      for (int ab = 0; ab < 2; ab++) begin
        qa[ab]   = qa_tab[ab][curve_select];
        ra[ab]   = ra_tab[ab][curve_select];
        half[ab] = half_tab[ab][curve_select];
        den[ab]  = den_tab[ab][curve_select];
        mq[ab]   = mq_tab[ab][curve_select];
      end
    end
  end

  // stage 1: clamp, split the phase into whole and remainder parts
  logic               s1_valid;
  logic               s1_end;
  logic [IDX_W-1:0]   s1_i;
  logic [T_W-1:0]     s1_t;
  logic [X_W-1:0]     s1_x [2];
  logic [PHASE_W-1:0] s1_q [2];

  logic [IDX_W-1:0]   i_next;
  logic [47:0]        t_prod;

  assign i_next = (step_index > n) ? n : step_index;
  assign t_prod = 48'(i_next) * 48'(CYC_MUL) + 48'(CYC_RND);

  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else s1_valid <= in_valid;
    s1_end <= (step_index >= n);
    s1_i   <= i_next;
    s1_t   <= t_prod[21 +: T_W];
    for (int ab = 0; ab < 2; ab++) begin
      s1_x[ab] <= X_W'(ra[ab] * i_next) + X_W'(half[ab]);
      s1_q[ab] <= PHASE_W'(qa[ab] * i_next);
    end
  end

  // stage 2: reciprocal estimate of the quotient
  logic               s2_valid;
  logic               s2_end;
  logic [IDX_W-1:0]   s2_i;
  logic [T_W-1:0]     s2_t;
  logic [X_W-1:0]     s2_x  [2];
  logic [PHASE_W-1:0] s2_q  [2];
  logic [R_W-1:0]     s2_r0 [2];
  logic [X_W+M_W-1:0] est   [2];

  always_comb begin
    for (int ab = 0; ab < 2; ab++) est[ab] = s1_x[ab] * mq[ab];
  end

  always_ff @(posedge clk) begin
    if (rst) s2_valid <= 1'b0;
    else s2_valid <= s1_valid;
    s2_end <= s1_end;
    s2_i   <= s1_i;
    s2_t   <= s1_t;
    for (int ab = 0; ab < 2; ab++) begin
      s2_x[ab]  <= s1_x[ab];
      s2_q[ab]  <= s1_q[ab];
      s2_r0[ab] <= est[ab][X_W +: R_W];
    end
  end

  // stage 3: correct the quotient and assemble the phase
  logic [R_W+DEN_W-1:0] back [2];
  logic [R_W+DEN_W-1:0] rem  [2];
  logic [R_W-1:0]       quo  [2];

  always_comb begin
    for (int ab = 0; ab < 2; ab++) begin
      back[ab] = s2_r0[ab] * den[ab];
      rem[ab]  = (R_W+DEN_W)'(s2_x[ab]) - back[ab];
      quo[ab]  = s2_r0[ab] + R_W'(rem[ab] >= (R_W+DEN_W)'(den[ab]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) phase_out.valid <= 1'b0;
    else phase_out.valid <= s2_valid;
    phase_out.at_end <= s2_end;
    phase_out.i      <= s2_i;
    phase_out.t      <= s2_t;
    phase_out.pa     <= s2_q[0] + PHASE_W'(quo[0]);
    phase_out.pb     <= s2_q[1] + PHASE_W'(quo[1]);
  end

endmodule

`default_nettype wire

>>> rtl/pcpg_point.sv
// ----------------------------------------------------------------------------
// pcpg_point
// Table lookups of the two phases and the curve equations in Q16.
// ----------------------------------------------------------------------------
`default_nettype none

module pcpg_point #(
  parameter int unsigned TABLE_BITS = pcpg_pkg::SINE_TABLE_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [pcpg_pkg::SEL_W-1:0] curve_select,
  input  pcpg_pkg::phase_t           phase_in,
  output pcpg_pkg::point_t           point_out
);
  import pcpg_pkg::*;

  localparam logic [TABLE_BITS:0]    QS       = (TABLE_BITS+1)'(1 << TABLE_BITS);
  localparam logic [PHASE_W-1:0]     QUARTER  = 32'h4000_0000;
  localparam logic signed [PT_W-1:0] ONE_PT   = PT_W'(ONE_Q16);
  localparam logic signed [VAL_W-1:0] ELL_B   = VAL_W'(ELLIPSE_B_Q16);
  localparam int unsigned            SQ_W     = 2 * VAL_W;
  localparam int unsigned            CUBE_W   = SQ_W + VAL_W;

  function automatic logic [TABLE_BITS:0] rom_addr(input logic [PHASE_W-1:0] ph);
    logic [30:0]         sum;
    logic [TABLE_BITS:0] pos;
    sum = {1'b0, ph[29:0]} + (31'd1 << (29 - TABLE_BITS));
    pos = sum[30 -: TABLE_BITS+1];
    if (ph[30]) pos = QS - pos;
    return pos;
  endfunction

  function automatic logic signed [PT_W-1:0] to_pt(input logic [ROM_W-1:0] d,
                                                   input logic neg);
    logic signed [PT_W-1:0] m;
    m = $signed({{(PT_W-ROM_W){1'b0}}, d});
    return neg ? -m : m;
  endfunction

  logic [PHASE_W-1:0] ph_ca, ph_cb;
  logic [ROM_W-1:0]   d_ca, d_sa, d_cb, d_sb;

  assign ph_ca = phase_in.pa + QUARTER;
  assign ph_cb = phase_in.pb + QUARTER;

  pcpg_sine_rom #(.TABLE_BITS(TABLE_BITS)) u_rom_ca (
    .clk(clk), .addr(rom_addr(ph_ca)), .data(d_ca)
  );
  pcpg_sine_rom #(.TABLE_BITS(TABLE_BITS)) u_rom_sa (
    .clk(clk), .addr(rom_addr(phase_in.pa)), .data(d_sa)
  );
  pcpg_sine_rom #(.TABLE_BITS(TABLE_BITS)) u_rom_cb (
    .clk(clk), .addr(rom_addr(ph_cb)), .data(d_cb)
  );
  pcpg_sine_rom #(.TABLE_BITS(TABLE_BITS)) u_rom_sb (
    .clk(clk), .addr(rom_addr(phase_in.pb)), .data(d_sb)
  );

  // stage 4: alongside the table read
  logic             s4_valid;
  logic             s4_end;
  logic [IDX_W-1:0] s4_i;
  logic [T_W-1:0]   s4_t;
  logic [3:0]       s4_neg;

  always_ff @(posedge clk) begin
    if (rst) s4_valid <= 1'b0;
    else s4_valid <= phase_in.valid;
    s4_end <= phase_in.at_end;
    s4_i   <= phase_in.i;
    s4_t   <= phase_in.t;
    s4_neg <= {phase_in.pb[31], ph_cb[31], phase_in.pa[31], ph_ca[31]};
  end

  // stage 5: signed values, linear curves, squares
  logic signed [PT_W-1:0]  ca, sa, cb, sb;
  logic signed [VAL_W-1:0] ca_n, sa_n;
  logic signed [SQ_W-1:0]  ell;
  logic signed [PT_W-1:0]  ell_y;
  logic signed [PT_W-1:0]  x_lin, y_lin;
  logic signed [PT_W-1:0]  line_v;
  logic signed [PT_W-1:0]  t_pt;

  assign ca   = to_pt(d_ca, s4_neg[0]);
  assign sa   = to_pt(d_sa, s4_neg[1]);
  assign cb   = to_pt(d_cb, s4_neg[2]);
  assign sb   = to_pt(d_sb, s4_neg[3]);
  assign ca_n = ca[VAL_W-1:0];
  assign sa_n = sa[VAL_W-1:0];
  assign ell  = ELL_B * sa_n;
  assign ell_y = PT_W'((ell + $signed({{(SQ_W-16){1'b0}}, {16{ell[SQ_W-1]}}})) >>> 16);
  assign line_v = ONE_PT - $signed({{(PT_W-IDX_W-10){1'b0}}, s4_i, 10'b0});
  assign t_pt   = $signed({{(PT_W-T_W){1'b0}}, s4_t});

  always_comb begin
    x_lin = '0;
    y_lin = '0;
    case (curve_t'(curve_select))
      CURVE_ASTROID: begin
        x_lin = '0;
        y_lin = '0;
      end
      CURVE_CYCLOID: begin
        x_lin = half_tz(PT_W'(3) * (ONE_PT - ca));
        y_lin = half_tz(PT_W'(3) * (t_pt - sa));
      end
      CURVE_HYPO: begin
        x_lin = half_tz(PT_W'(3) * ((ca <<< 1) + cb));
        y_lin = half_tz(PT_W'(3) * ((sa <<< 1) - sb));
      end
      CURVE_HUYGENS: begin
        x_lin = (PT_W'(3) * ca - cb) <<< 2;
        y_lin = (PT_W'(3) * sa - sb) <<< 2;
      end
      CURVE_LINE: begin
        x_lin = line_v;
        y_lin = line_v;
      end
      CURVE_CIRCLE: begin
        x_lin = ca;
        y_lin = sa;
      end
      CURVE_ELLIPSE: begin
        x_lin = ca <<< 1;
        y_lin = ell_y;
      end
      CURVE_FANCY: begin
        x_lin = PT_W'(11) * ca - PT_W'(6) * cb;
        y_lin = PT_W'(11) * sa - PT_W'(6) * sb;
      end
      CURVE_STARFISH: begin
        x_lin = (ca <<< 1) + PT_W'(5) * cb;
        y_lin = (sa <<< 1) - PT_W'(5) * sb;
      end
      CURVE_CLOUD: begin
        x_lin = PT_W'(15) * ca - cb;
        y_lin = PT_W'(15) * sa - sb;
      end
      CURVE_ICLOUD: begin
        x_lin = PT_W'(15) * ca + cb;
        y_lin = PT_W'(15) * sa - sb;
      end
      default: begin
        x_lin = '0;
        y_lin = '0;
      end
    endcase
  end

  logic                    s5_valid;
  logic                    s5_end;
  logic signed [PT_W-1:0]  s5_x, s5_y;
  logic signed [SQ_W-1:0]  s5_cc, s5_ss;
  logic signed [VAL_W-1:0] s5_c, s5_s;

  always_ff @(posedge clk) begin
    if (rst) s5_valid <= 1'b0;
    else s5_valid <= s4_valid;
    s5_end <= s4_end;
    s5_x   <= x_lin;
    s5_y   <= y_lin;
    s5_cc  <= ca_n * ca_n;
    s5_ss  <= sa_n * sa_n;
    s5_c   <= ca_n;
    s5_s   <= sa_n;
  end

  // stage 6: cubes for the astroid, final selection
  logic signed [CUBE_W-1:0] cube_x, cube_y;
  logic signed [CUBE_W:0]   dbl_x, dbl_y;
  logic signed [CUBE_W:0]   adj_x, adj_y;
  logic signed [PT_W-1:0]   ast_x, ast_y;

  assign cube_x = s5_cc * s5_c;
  assign cube_y = s5_ss * s5_s;
  assign dbl_x  = {cube_x, 1'b0};
  assign dbl_y  = {cube_y, 1'b0};
  assign adj_x  = dbl_x + $signed({{(CUBE_W+1-32){1'b0}}, {32{dbl_x[CUBE_W]}}});
  assign adj_y  = dbl_y + $signed({{(CUBE_W+1-32){1'b0}}, {32{dbl_y[CUBE_W]}}});
  assign ast_x  = PT_W'(adj_x >>> 32);
  assign ast_y  = PT_W'(adj_y >>> 32);

  always_ff @(posedge clk) begin
    if (rst) point_out.valid <= 1'b0;
    else point_out.valid <= s5_valid;
    point_out.at_end <= s5_end;
    if (curve_t'(curve_select) == CURVE_ASTROID) begin
      point_out.x <= ast_x;
      point_out.y <= ast_y;
    end else begin
      point_out.x <= s5_x;
      point_out.y <= s5_y;
    end
  end

endmodule

`default_nettype wire

>>> rtl/pcpg_checker.sv
// ----------------------------------------------------------------------------
// pcpg_checker
// Port-level timing checks of the curve point generator, bound to the core.
// ----------------------------------------------------------------------------
`default_nettype none

module pcpg_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       start,
  input logic                       busy,
  input logic [pcpg_pkg::IDX_W-1:0] step_index,
  input logic                       done,
  input logic                       end_of_curve
);
  import pcpg_pkg::*;

  a_result_has_transfer: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result without a matching transfer");

  a_not_end_in_range: assert property (@(posedge clk) disable iff (rst)
    (done && !end_of_curve) |-> ($past(step_index, LATENCY) < 10'd512))
    else $error("end_of_curve low for an index beyond any step count");

  a_quiet_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !done)
    else $error("result right after reset");

endmodule

bind parametric_curve_point_generator_core pcpg_checker u_pcpg_checker (.*);

`default_nettype wire
